FILE: design/rtp_pkg.sv
package rtp_pkg;

   // Field widths and internal scaling
   localparam int DATA_WIDTH       = 24;
   localparam int CORDIC_STAGES    = 24;
   localparam int GUARD_BITS       = 8;
   localparam int ANGLE_GUARD      = 8;
   localparam int ANGLE_SCALE_BITS = DATA_WIDTH - 1 + ANGLE_GUARD;
   localparam int ANGLE_WIDTH      = DATA_WIDTH + 1;

   // x/y datapath: input magnitude times guard scale times CORDIC gain, signed
   localparam int XW      = DATA_WIDTH + GUARD_BITS + 2;
   // angle accumulator: +-pi preset plus the sum of all micro-rotation steps
   localparam int ZW      = ANGLE_SCALE_BITS + 2;
   localparam int SHIFT_W = $clog2(CORDIC_STAGES);

   // Pipeline depth from accepted beat to result strobe
   localparam int LATENCY = CORDIC_STAGES + 4;

   // pi on the accumulator scale
   localparam logic signed [ZW-1:0] ANGLE_PI = ZW'(64'd1 << ANGLE_SCALE_BITS);

   // atan(2^-i)/pi on the accumulator scale, rounded half up
   localparam logic signed [ZW-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81
   };

   // Top 64 bits of a 64x64 product
   function automatic logic [63:0] mul_high(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[127:64];
   endfunction

   // Inverse CORDIC gain in Q62: largest c with c*c*prod(1+2^-2i) <= 1
   function automatic logic [61:0] calc_inv_gain();
      logic [63:0] p;
      logic [63:0] c;
      logic [63:0] t;
      logic [63:0] sq;
      p = 64'd1 << 62;
      c = 64'd0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      for (int b = 61; b >= 0; b--) begin
         t  = c | (64'd1 << b);
         sq = mul_high(t, t);
         if (mul_high(sq, p) <= (64'd1 << 58)) begin
            c = t;
         end
      end
      return c[61:0];
   endfunction

   localparam int          INV_GAIN_W = 62;
   localparam int          GAIN_LO_W  = INV_GAIN_W / 2;
   localparam int          GAIN_HI_W  = INV_GAIN_W - GAIN_LO_W;
   localparam logic [61:0] INV_GAIN   = calc_inv_gain();

   // Payload handed from cell to cell
   typedef struct packed {
      logic                 zero;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } rtp_vec_type;

endpackage

FILE: design/rtp_prerotate.sv
module rtp_prerotate (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic signed [rtp_pkg::DATA_WIDTH-1:0] real_part,
   input  logic signed [rtp_pkg::DATA_WIDTH-1:0] imag_part,
   output logic                                  out_valid,
   output rtp_pkg::rtp_vec_type                  out_vec
);
   import rtp_pkg::*;

   logic                 valid_ff;
   rtp_vec_type          vec_ff;
   rtp_vec_type          vec_in;
   logic signed [XW-1:0] re_ext;
   logic signed [XW-1:0] im_ext;

   // Fold the left half plane onto the right one, preset the angle to +-pi
   always_comb begin
      re_ext      = XW'(real_part);
      im_ext      = XW'(imag_part);
      vec_in.zero = (real_part == '0) && (imag_part == '0);
      if (real_part[DATA_WIDTH-1]) begin
         vec_in.x = (-re_ext) <<< GUARD_BITS;
         vec_in.y = (-im_ext) <<< GUARD_BITS;
         vec_in.z = imag_part[DATA_WIDTH-1] ? -ANGLE_PI : ANGLE_PI;
      end else begin
         vec_in.x = re_ext <<< GUARD_BITS;
         vec_in.y = im_ext <<< GUARD_BITS;
         vec_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

FILE: design/rtp_cell.sv
module rtp_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rtp_pkg::SHIFT_W-1:0]       shift,
   input  logic signed [rtp_pkg::ZW-1:0]     atan_step,
   input  logic                              in_valid,
   input  rtp_pkg::rtp_vec_type              in_vec,
   output logic                              out_valid,
   output rtp_pkg::rtp_vec_type              out_vec
);
   import rtp_pkg::*;

   logic                 valid_ff;
   rtp_vec_type          vec_ff;
   rtp_vec_type          vec_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   // One micro-rotation toward the real axis
   always_comb begin
      xs          = in_vec.x >>> shift;
      ys          = in_vec.y >>> shift;
      vec_in.zero = in_vec.zero;
      if (in_vec.y[XW-1]) begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - atan_step;
      end else begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

FILE: design/rtp_gain.sv
module rtp_gain (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  rtp_pkg::rtp_vec_type                    in_vec,
   output logic                                    out_valid,
   output logic [rtp_pkg::DATA_WIDTH-1:0]          magnitude,
   output logic signed [rtp_pkg::ANGLE_WIDTH-1:0]  angle
);
   import rtp_pkg::*;

   localparam int XMAG_W = XW - 1;
   localparam int PART_W = XMAG_W + GAIN_LO_W;
   localparam int SUM_W  = XMAG_W + INV_GAIN_W;
   localparam int M_W    = SUM_W - INV_GAIN_W;
   localparam int RND_W  = M_W + 1;
   localparam int MAGF_W = RND_W - GUARD_BITS;
   localparam int ZR_W   = ZW + 1;
   localparam int ANGF_W = ZR_W - ANGLE_GUARD;

   localparam logic [GAIN_LO_W-1:0] GAIN_LO = INV_GAIN[GAIN_LO_W-1:0];
   localparam logic [GAIN_HI_W-1:0] GAIN_HI = INV_GAIN[INV_GAIN_W-1:GAIN_LO_W];
   localparam logic [MAGF_W-1:0]    MAG_MAX = MAGF_W'({DATA_WIDTH{1'b1}});
   localparam logic signed [ANGF_W-1:0] HALF_TURN = ANGF_W'(64'd1 << (DATA_WIDTH - 1));

   // stage 1: partial products, rounded angle
   logic                          valid1_ff;
   logic                          zero1_ff;
   logic [PART_W-1:0]             plo1_ff;
   logic [PART_W-1:0]             phi1_ff;
   logic signed [ANGLE_WIDTH-1:0] ang1_ff;
   logic [XMAG_W-1:0]             xmag;
   logic [PART_W-1:0]             plo1_in;
   logic [PART_W-1:0]             phi1_in;
   logic signed [ZR_W-1:0]        z_round;
   logic signed [ANGF_W-1:0]      ang_full;
   logic signed [ANGLE_WIDTH-1:0] ang1_in;

   // stage 2: scaled magnitude before rounding
   logic                          valid2_ff;
   logic                          zero2_ff;
   logic [M_W-1:0]                m2_ff;
   logic signed [ANGLE_WIDTH-1:0] ang2_ff;
   logic [SUM_W-1:0]              sum2;

   // stage 3: result registers
   logic                          valid3_ff;
   logic [DATA_WIDTH-1:0]         mag3_ff;
   logic signed [ANGLE_WIDTH-1:0] ang3_ff;
   logic [RND_W-1:0]              mag_sum;
   logic [MAGF_W-1:0]             mag_full;
   logic [DATA_WIDTH-1:0]         mag3_in;

   // Clamp x, split the gain constant, round and saturate the angle
   always_comb begin
      xmag     = in_vec.x[XW-1] ? '0 : in_vec.x[XMAG_W-1:0];
      plo1_in  = PART_W'(xmag) * PART_W'(GAIN_LO);
      phi1_in  = PART_W'(xmag) * PART_W'(GAIN_HI);
      z_round  = ZR_W'(in_vec.z) + ZR_W'(64'd1 << (ANGLE_GUARD - 1));
      ang_full = z_round[ZR_W-1:ANGLE_GUARD];
      if (ang_full > HALF_TURN) begin
         ang1_in = ANGLE_WIDTH'(HALF_TURN);
      end else if (ang_full < -HALF_TURN) begin
         ang1_in = ANGLE_WIDTH'(-HALF_TURN);
      end else begin
         ang1_in = ang_full[ANGLE_WIDTH-1:0];
      end
   end

   // Recombine partial products, keep bits above Q62
   assign sum2 = {phi1_ff, {GAIN_LO_W{1'b0}}} + SUM_W'(plo1_ff);

   // Round half up by the guard bits, saturate, force zero for a zero sample
   always_comb begin
      mag_sum  = RND_W'(m2_ff) + RND_W'(64'd1 << (GUARD_BITS - 1));
      mag_full = mag_sum[RND_W-1:GUARD_BITS];
      if (zero2_ff) begin
         mag3_in = '0;
      end else if (mag_full > MAG_MAX) begin
         mag3_in = MAG_MAX[DATA_WIDTH-1:0];
      end else begin
         mag3_in = mag_full[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      zero1_ff <= in_vec.zero;
      plo1_ff  <= plo1_in;
      phi1_ff  <= phi1_in;
      ang1_ff  <= ang1_in;
      zero2_ff <= zero1_ff;
      m2_ff    <= sum2[SUM_W-1:INV_GAIN_W];
      ang2_ff  <= ang1_ff;
      mag3_ff  <= mag3_in;
      ang3_ff  <= zero2_ff ? '0 : ang2_ff;
   end

   assign out_valid = valid3_ff;
   assign magnitude = mag3_ff;
   assign angle     = ang3_ff;

endmodule

FILE: design/rect_to_polar_converter.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   -------------------------------
// request   req_real_part, req_imag_part            beat taken when start && !busy
// response  rsp_magnitude, rsp_angle                beat shown one cycle, rsp_valid
//
// Fully pipelined: one beat accepted every cycle, busy stays low.
// Pipeline: one fold register, one cell per micro-rotation, then two
// multiply stages and one rounding/output register. Synchronous active-high
// reset clears the valid chain; data registers keep whatever they held. The
// receiver cannot stall, so nothing backs up.
module rect_to_polar_converter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [rtp_pkg::DATA_WIDTH-1:0]   req_real_part,
   input  logic signed [rtp_pkg::DATA_WIDTH-1:0]   req_imag_part,
   output logic                                    rsp_valid,
   output logic [rtp_pkg::DATA_WIDTH-1:0]          rsp_magnitude,
   output logic signed [rtp_pkg::ANGLE_WIDTH-1:0]  rsp_angle
);
   import rtp_pkg::*;

   logic        valid_chain [CORDIC_STAGES+1];
   rtp_vec_type vec_chain   [CORDIC_STAGES+1];

   assign busy = 1'b0;

   // Quadrant fold and input register
   rtp_prerotate u_prerotate (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .real_part (req_real_part),
      .imag_part (req_imag_part),
      .out_valid (valid_chain[0]),
      .out_vec   (vec_chain[0])
   );

   // Row of micro-rotation cells
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      rtp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (SHIFT_W'(k)),
         .atan_step (ATAN_TABLE[k]),
         .in_valid  (valid_chain[k]),
         .in_vec    (vec_chain[k]),
         .out_valid (valid_chain[k+1]),
         .out_vec   (vec_chain[k+1])
      );
   end

   // Gain compensation, rounding, output registers
   rtp_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[CORDIC_STAGES]),
      .in_vec    (vec_chain[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .magnitude (rsp_magnitude),
      .angle     (rsp_angle)
   );

endmodule

FILE: design/rtp_checker.sv
module rtp_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    start,
   input logic                                    busy,
   input logic signed [rtp_pkg::DATA_WIDTH-1:0]   req_real_part,
   input logic signed [rtp_pkg::DATA_WIDTH-1:0]   req_imag_part,
   input logic                                    rsp_valid,
   input logic [rtp_pkg::DATA_WIDTH-1:0]          rsp_magnitude,
   input logic signed [rtp_pkg::ANGLE_WIDTH-1:0]  rsp_angle
);
   import rtp_pkg::*;

   localparam int WARM_W = $clog2(LATENCY + 1);
   localparam logic [DATA_WIDTH-1:0] MAG_LIMIT = DATA_WIDTH'(11863284);
   localparam logic signed [ANGLE_WIDTH-1:0] HALF_TURN =
      ANGLE_WIDTH'(64'd1 << (DATA_WIDTH - 1));

   logic [WARM_W-1:0] warm_ff;
   logic              warm;

   // Cycles since reset, saturating at the pipeline depth
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else if (warm_ff != WARM_W'(LATENCY)) begin
         warm_ff <= warm_ff + 1'b1;
      end
   end

   assign warm = (warm_ff == WARM_W'(LATENCY));

   // Every accepted beat gives exactly one strobe, a fixed depth later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      warm |-> (rsp_valid == $past(start && !busy, LATENCY)))
      else $error("response strobe does not match accepted beat");

   // Zero sample returns zero modulus and zero phase
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (warm && rsp_valid && $past(req_real_part == '0 && req_imag_part == '0, LATENCY))
      |-> (rsp_magnitude == '0 && rsp_angle == '0))
      else $error("zero sample gave nonzero result");

   // Modulus stays within the reachable range
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_magnitude <= MAG_LIMIT))
      else $error("magnitude out of range");

   // Phase stays within plus or minus pi
   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle <= HALF_TURN && rsp_angle >= -HALF_TURN))
      else $error("angle out of range");

endmodule

bind rect_to_polar_converter rtp_checker u_rtp_checker (.*);
